// File: design/pqbs_pkg.sv
// ----------------------------------------------------------------------------
// pqbs_pkg
// Shared types and constants of the priority quota batch scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pqbs_pkg;

   // Number of priority queues; queue 0 is the highest priority.
   localparam int NUM_QUEUES  = 3;
   // Largest pending count that a queue may reach.
   localparam longint unsigned MAX_PENDING = 65535;

   localparam int CNT_W    = 16;   // pending count and grant count width
   localparam int TOK_W    = 18;   // token count width
   localparam int CAP_W    = 18;   // capacity limit width
   localparam int QSEL_W   = 2;    // queue field width on the ports
   localparam int NUM_QUOTA = 3;   // queues that own a quota register
   localparam int QIDX_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int TOT_W    = CNT_W + QIDX_W;
   localparam int CMP_W    = (TOT_W > TOK_W) ? TOT_W : TOK_W;
   localparam int CMPC_W   = (CMP_W > CAP_W) ? CMP_W : CAP_W;

   // Highest count that an enqueue may raise a queue to.
   localparam logic [CNT_W-1:0] COUNT_CEIL =
      (MAX_PENDING < 65535) ? CNT_W'(MAX_PENDING) : CNT_W'(65535);

   // Register file layout.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_QUOTA_ZERO = 2'd0,
      REG_QUOTA_ONE  = 2'd1,
      REG_QUOTA_TWO  = 2'd2,
      REG_CAPACITY   = 2'd3
   } reg_index_type;

   localparam logic [CNT_W-1:0] QUOTA_RESET    = CNT_W'(1);
   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(262143);

   typedef enum logic [1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_GRANT    = 2'd1,
      OP_SHUTDOWN = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_ENQUEUE  = 2'd0,
      KIND_GRANT    = 2'd1,
      KIND_SHUTDOWN = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_DROPPED  = 2'd2
   } status_type;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

endpackage : pqbs_pkg

`default_nettype wire

// File: design/priority_quota_batch_scheduler.sv
// ----------------------------------------------------------------------------
// priority_quota_batch_scheduler
// Strict-priority batch scheduler that keeps a pending count per queue and
// splits a batch of tokens over the queues by quota, then by priority.
// ----------------------------------------------------------------------------
//
//  Port group  Direction  Role
//  ----------  ---------  ---------------------------------------------------
//  req_*       in         operations: enqueue, batch grant, shutdown
//  rsp_*       out        enqueue status, one grant per queue, shutdown ack
//  csr_*       in/out     quota and capacity registers
//
//  Enqueue and shutdown results are registered into the output register. A
//  batch grant runs the quota pass and the leftover pass (both skipped
//  after shutdown) before its grants leave, one per cycle while rsp_tready
//  is high: a single min/subtract unit visits each queue once for the quota
//  pass and once for the leftover pass. Reset clears the pending counts, the
//  shutdown flag and the registers to their defaults. A stalled result port
//  holds the block in place; a new transaction is taken once the sequencer
//  is idle and the output register is free or drained in the same cycle.
//
`default_nettype none

module priority_quota_batch_scheduler
   import pqbs_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,

   input  wire                    req_tvalid,
   output logic                   req_tready,
   // [1:0] queue_index, [19:2] token_count, [23:20] zero
   input  wire  [REQ_DATA_W-1:0]  req_tdata,
   // [1:0] op
   input  wire  [1:0]             req_tuser,

   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // [1:0] status, [2] full_flag, [4:3] grant_queue, [20:5] grant_count,
   // [23:21] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] kind
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast,

   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  wire  [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS1,
      ST_PASS2,
      ST_EMIT
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          pending_ff [NUM_QUEUES];
   logic [CNT_W-1:0]          pending_in [NUM_QUEUES];
   logic [CNT_W-1:0]          grant_ff   [NUM_QUEUES];
   logic [CNT_W-1:0]          grant_in   [NUM_QUEUES];
   logic [CNT_W-1:0]          quota_ff   [NUM_QUOTA];
   logic [CNT_W-1:0]          quota_in   [NUM_QUOTA];
   logic [CAP_W-1:0]          cap_ff, cap_in;
   logic                      shut_ff, shut_in;
   logic [TOK_W-1:0]          tok_ff, tok_in;
   logic [QIDX_W-1:0]         qidx_ff, qidx_in;
   logic                      gstat_ff, gstat_in;

   logic                      ov_ff, ov_in;
   kind_type                  okind_ff, okind_in;
   status_type                ostat_ff, ostat_in;
   logic                      ofull_ff, ofull_in;
   logic [QSEL_W-1:0]         oqueue_ff, oqueue_in;
   logic [CNT_W-1:0]          ocount_ff, ocount_in;
   logic                      olast_ff, olast_in;

   logic                      out_free;
   logic                      req_fire;
   logic                      csr_wr;
   logic [TOT_W-1:0]          total;
   logic [QIDX_W-1:0]         enq_q;
   logic [QIDX_W-1:0]         rd_idx;
   logic [CNT_W-1:0]          rd_pend;
   logic [CNT_W-1:0]          rd_grant;
   logic [CNT_W-1:0]          rd_quota;
   logic [CNT_W-1:0]          avail;
   logic [CNT_W-1:0]          unit_g;
   logic [TOK_W-1:0]          unit_rem;
   logic                      enq_ok;
   logic [TOT_W-1:0]          total_after;
   logic [TOK_W-1:0]          req_tokens;
   logic [TOK_W-1:0]          tok_clamped;
   logic                      is_last_q;

   assign out_free   = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   assign req_tokens = req_tdata[QSEL_W +: TOK_W];

   // Total pending over all queues.
   always_comb begin
      total = '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         total = total + TOT_W'(pending_ff[i]);
      end
   end

   // Enqueues aimed beyond the last queue go to the lowest priority queue.
   always_comb begin
      if (int'(req_tdata[QSEL_W-1:0]) >= NUM_QUEUES) begin
         enq_q = QIDX_W'(NUM_QUEUES - 1);
      end else begin
         enq_q = QIDX_W'(req_tdata[QSEL_W-1:0]);
      end
   end

   assign rd_idx   = (state_ff == ST_IDLE) ? enq_q : qidx_ff;
   assign rd_pend  = pending_ff[rd_idx];
   assign rd_grant = grant_ff[rd_idx];

   // Queues without a quota register have a quota of zero.
   always_comb begin
      rd_quota = '0;
      for (int k = 0; k < NUM_QUOTA; k++) begin
         if (QIDX_W'(k) == qidx_ff && k < NUM_QUEUES) begin
            rd_quota = quota_ff[k];
         end
      end
   end

   // Shared min/subtract unit. The quota pass offers the lesser of pending
   // and quota, the leftover pass what remains pending after that.
   always_comb begin
      if (state_ff == ST_PASS1) begin
         avail = (rd_pend < rd_quota) ? rd_pend : rd_quota;
      end else begin
         avail = rd_pend - rd_grant;
      end
      if (TOK_W'(avail) < tok_ff) begin
         unit_g = avail;
      end else begin
         unit_g = CNT_W'(tok_ff);
      end
      unit_rem = tok_ff - TOK_W'(unit_g);
   end

   assign enq_ok      = !shut_ff && (rd_pend < COUNT_CEIL);
   assign total_after = total + TOT_W'(enq_ok);
   assign tok_clamped = (CMP_W'(req_tokens) > CMP_W'(total)) ? TOK_W'(total) : req_tokens;
   assign is_last_q   = (qidx_ff == QIDX_W'(NUM_QUEUES - 1));

   always_comb begin
      state_in  = state_ff;
      pending_in = pending_ff;
      grant_in  = grant_ff;
      quota_in  = quota_ff;
      cap_in    = cap_ff;
      shut_in   = shut_ff;
      tok_in    = tok_ff;
      qidx_in   = qidx_ff;
      gstat_in  = gstat_ff;

      ov_in     = ov_ff && !rsp_tready;
      okind_in  = okind_ff;
      ostat_in  = ostat_ff;
      ofull_in  = ofull_ff;
      oqueue_in = oqueue_ff;
      ocount_in = ocount_ff;
      olast_in  = olast_ff;

      if (csr_wr) begin
         unique case (reg_index_type'(csr_paddr[3:2]))
            REG_QUOTA_ZERO: quota_in[0] = csr_pwdata[CNT_W-1:0];
            REG_QUOTA_ONE:  quota_in[1] = csr_pwdata[CNT_W-1:0];
            REG_QUOTA_TWO:  quota_in[2] = csr_pwdata[CNT_W-1:0];
            REG_CAPACITY:   cap_in      = csr_pwdata[CAP_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  OP_ENQUEUE: begin
                     if (enq_ok) begin
                        pending_in[rd_idx] = rd_pend + CNT_W'(1);
                     end
                     ov_in     = 1'b1;
                     okind_in  = KIND_ENQUEUE;
                     ostat_in  = shut_ff ? STATUS_REJECTED
                               : (enq_ok ? STATUS_OK : STATUS_DROPPED);
                     ofull_in  = CMPC_W'(total_after) >= CMPC_W'(cap_ff);
                     oqueue_in = QSEL_W'(enq_q);
                     ocount_in = '0;
                     olast_in  = 1'b1;
                  end
                  OP_GRANT: begin
                     for (int i = 0; i < NUM_QUEUES; i++) begin
                        grant_in[i] = '0;
                     end
                     tok_in   = tok_clamped;
                     gstat_in = shut_ff;
                     qidx_in  = '0;
                     state_in = shut_ff ? ST_EMIT : ST_PASS1;
                  end
                  OP_SHUTDOWN: begin
                     shut_in   = 1'b1;
                     ov_in     = 1'b1;
                     okind_in  = KIND_SHUTDOWN;
                     ostat_in  = STATUS_OK;
                     ofull_in  = CMPC_W'(total) >= CMPC_W'(cap_ff);
                     oqueue_in = '0;
                     ocount_in = '0;
                     olast_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PASS1: begin
            grant_in[qidx_ff] = unit_g;
            tok_in = unit_rem;
            if (is_last_q) begin
               qidx_in  = '0;
               state_in = ST_PASS2;
            end else begin
               qidx_in = qidx_ff + QIDX_W'(1);
            end
         end
         ST_PASS2: begin
            // The leftover pass also retires this queue's whole grant.
            grant_in[qidx_ff]   = rd_grant + unit_g;
            pending_in[qidx_ff] = avail - unit_g;
            tok_in = unit_rem;
            if (is_last_q) begin
               qidx_in  = '0;
               state_in = ST_EMIT;
            end else begin
               qidx_in = qidx_ff + QIDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ov_in     = 1'b1;
               okind_in  = KIND_GRANT;
               ostat_in  = gstat_ff ? STATUS_REJECTED : STATUS_OK;
               ofull_in  = CMPC_W'(total) >= CMPC_W'(cap_ff);
               oqueue_in = QSEL_W'(qidx_ff);
               ocount_in = rd_grant;
               olast_in  = is_last_q;
               if (is_last_q) begin
                  qidx_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  qidx_in = qidx_ff + QIDX_W'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            pending_ff[i] <= '0;
         end
         for (int k = 0; k < NUM_QUOTA; k++) begin
            quota_ff[k] <= QUOTA_RESET;
         end
         cap_ff  <= CAPACITY_RESET;
         shut_ff <= 1'b0;
         qidx_ff <= '0;
         ov_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         quota_ff   <= quota_in;
         cap_ff     <= cap_in;
         shut_ff    <= shut_in;
         qidx_ff    <= qidx_in;
         ov_ff      <= ov_in;
      end
      grant_ff  <= grant_in;
      tok_ff    <= tok_in;
      gstat_ff  <= gstat_in;
      okind_ff  <= okind_in;
      ostat_ff  <= ostat_in;
      ofull_ff  <= ofull_in;
      oqueue_ff <= oqueue_in;
      ocount_ff <= ocount_in;
      olast_ff  <= olast_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {(RSP_DATA_W - 21)'(0), ocount_ff, oqueue_ff, ofull_ff, ostat_ff};

   always_comb begin
      unique case (reg_index_type'(csr_paddr[3:2]))
         REG_QUOTA_ZERO: csr_prdata = CSR_DATA_W'(quota_ff[0]);
         REG_QUOTA_ONE:  csr_prdata = CSR_DATA_W'(quota_ff[1]);
         REG_QUOTA_TWO:  csr_prdata = CSR_DATA_W'(quota_ff[2]);
         REG_CAPACITY:   csr_prdata = CSR_DATA_W'(cap_ff);
      endcase
   end

endmodule : priority_quota_batch_scheduler

`default_nettype wire

// File: verif/priority_quota_batch_scheduler_test.sv
// ----------------------------------------------------------------------------
// priority_quota_batch_scheduler_test
// Self-checking bench for the priority quota batch scheduler: directed enqueue
// and grant requests, random traffic under several quota and capacity settings,
// then a directed shutdown. A scoreboard tracks the per-queue counts and
// checks every result transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_quota_batch_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pqbs_pkg::*;

   localparam logic [1:0]  OP_UNUSED       = 2'd3;
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   localparam int unsigned LONG_HOLD_OFF   = 400;
   localparam int unsigned SETTLE_CYCLES   = 16;
   localparam int unsigned RANDOM_PHASES   = 6;
   localparam int unsigned ITEMS_PER_PHASE = 70;
   localparam int unsigned BURST_LENGTH    = 6;

   typedef struct {
      kind_type          kind;
      status_type        status;
      logic              full;
      logic [QSEL_W-1:0] queue;
      logic [CNT_W-1:0]  count;
      logic              last;
   } sched_result_type;

   class batch_tracker;
      logic [CNT_W-1:0] pending [NUM_QUEUES];
      logic [CNT_W-1:0] quota [NUM_QUOTA];
      logic [CAP_W-1:0] capacity;
      bit               shut_down;
      sched_result_type awaited [$];
      int unsigned      failures;

      function new();
         foreach (pending[i]) pending[i] = '0;
         foreach (quota[i]) quota[i] = QUOTA_RESET;
         capacity  = CAPACITY_RESET;
         shut_down = 1'b0;
         failures  = 0;
      endfunction

      function longint unsigned total_pending();
         longint unsigned sum;
         sum = 0;
         foreach (pending[i]) sum += pending[i];
         return sum;
      endfunction

      function longint unsigned quota_of(int q);
         return (q < NUM_QUOTA) ? quota[q] : 0;
      endfunction

      function void write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_CAPACITY) capacity = value[CAP_W-1:0];
         else quota[idx] = value[CNT_W-1:0];
      endfunction

      function logic [CSR_DATA_W-1:0] register_value(reg_index_type idx);
         if (idx == REG_CAPACITY) return CSR_DATA_W'(capacity);
         return CSR_DATA_W'(quota[idx]);
      endfunction

      // The full flag reflects the counts after the whole request is applied.
      function void await_result(kind_type kind, status_type status, int unsigned queue,
                                 longint unsigned count, bit last);
         sched_result_type r;
         r.kind   = kind;
         r.status = status;
         r.full   = (total_pending() >= capacity);
         r.queue  = QSEL_W'(queue);
         r.count  = CNT_W'(count);
         r.last   = last;
         awaited.push_back(r);
      endfunction

      function void note_request(logic [1:0] op, logic [QSEL_W-1:0] queue_sel,
                                 logic [TOK_W-1:0] tokens);
         int unsigned     q;
         longint unsigned left;
         longint unsigned share;
         longint unsigned granted [NUM_QUEUES];
         status_type      st;
         case (op)
            OP_ENQUEUE: begin
               q = (queue_sel < NUM_QUEUES) ? queue_sel : NUM_QUEUES - 1;
               if (shut_down) begin
                  st = STATUS_REJECTED;
               end else if (pending[q] >= COUNT_CEIL) begin
                  st = STATUS_DROPPED;
               end else begin
                  st = STATUS_OK;
                  pending[q] = pending[q] + 1'b1;
               end
               await_result(KIND_ENQUEUE, st, q, 0, 1'b1);
            end
            OP_GRANT: begin
               foreach (granted[i]) granted[i] = 0;
               if (!shut_down) begin
                  left = tokens;
                  if (left > total_pending()) left = total_pending();
                  // Guaranteed share first, then leftovers again by priority.
                  for (int i = 0; i < NUM_QUEUES; i++) begin
                     share = pending[i];
                     if (share > quota_of(i)) share = quota_of(i);
                     if (share > left) share = left;
                     granted[i] = share;
                     left -= share;
                  end
                  for (int i = 0; i < NUM_QUEUES; i++) begin
                     share = pending[i] - granted[i];
                     if (share > left) share = left;
                     granted[i] += share;
                     left -= share;
                  end
                  foreach (pending[i]) pending[i] = pending[i] - CNT_W'(granted[i]);
               end
               for (int i = 0; i < NUM_QUEUES; i++) begin
                  await_result(KIND_GRANT, shut_down ? STATUS_REJECTED : STATUS_OK, i,
                               granted[i], i == NUM_QUEUES - 1);
               end
            end
            OP_SHUTDOWN: begin
               shut_down = 1'b1;
               await_result(KIND_SHUTDOWN, STATUS_OK, 0, 0, 1'b1);
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(logic [1:0] kind, logic [1:0] status, logic full,
                                 logic [QSEL_W-1:0] queue, logic [CNT_W-1:0] count,
                                 logic last);
         sched_result_type want;
         if (awaited.size() == 0) begin
            $error("result with nothing outstanding: kind %0d queue %0d count %0d",
                   kind, queue, count);
            failures++;
            return;
         end
         want = awaited.pop_front();
         compare_field("kind", want.kind, kind);
         compare_field("status", want.status, status);
         compare_field("full_flag", want.full, full);
         compare_field("grant_queue", want.queue, queue);
         compare_field("grant_count", want.count, count);
         compare_field("last", want.last, last);
      endfunction

      function void check_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         compare_field({"register ", idx.name()}, register_value(idx), value);
      endfunction
   endclass

   logic                  clock;
   logic                  reset       = 1'b1;

   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // [1:0] queue_index, [19:2] token_count, [23:20] zero
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   // [1:0] op
   logic [1:0]            req_tuser   = '0;

   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // [1:0] status, [2] full_flag, [4:3] grant_queue, [20:5] grant_count, [23:21] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [1:0] kind
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bit steady_flow      = 1'b0;
   bit hold_off_request = 1'b0;

   batch_tracker tracker;

   priority_quota_batch_scheduler dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_quota();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return CSR_DATA_W'(16'hFFFF);
      return $urandom_range(1, 4);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_request(req_tuser, req_tdata[1:0], req_tdata[19:2]);
         if (rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tuser, rsp_tdata[1:0], rsp_tdata[2], rsp_tdata[4:3],
                                 rsp_tdata[20:5], rsp_tlast);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite)
               tracker.write_register(reg_index_type'(csr_paddr[3:2]), csr_pwdata);
            else
               tracker.check_register(reg_index_type'(csr_paddr[3:2]), csr_prdata);
         end
      end
   end

   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_OFF) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (1 + idle_length()) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   task automatic send_request(logic [1:0] op, logic [QSEL_W-1:0] queue_sel,
                               logic [TOK_W-1:0] tokens);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({tokens, queue_sel});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = steady_flow ? 0 : idle_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_request();
      int unsigned      pick;
      logic [TOK_W-1:0] tokens;
      pick   = $urandom_range(0, 99);
      tokens = TOK_W'($urandom);
      if (pick < 55) begin
         send_request(OP_ENQUEUE, QSEL_W'($urandom), tokens);
      end else if (pick < 94) begin
         if ($urandom_range(0, 3) != 0)
            tokens = TOK_W'($urandom_range(0, int'(tracker.total_pending()) + 2));
         send_request(OP_GRANT, QSEL_W'($urandom), tokens);
      end else begin
         send_request(OP_UNUSED, QSEL_W'($urandom), tokens);
      end
   endtask

   // An ignored request leaves nothing outstanding, so allow the sequencer
   // time to settle before the registers are touched.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(bit write, reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel   <= 1'b1;
      csr_pwrite <= write;
      csr_paddr  <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(logic [CSR_DATA_W-1:0] quota_zero,
                                logic [CSR_DATA_W-1:0] quota_one,
                                logic [CSR_DATA_W-1:0] quota_two,
                                logic [CSR_DATA_W-1:0] cap);
      csr_access(1'b1, REG_QUOTA_ZERO, quota_zero);
      csr_access(1'b1, REG_QUOTA_ONE, quota_one);
      csr_access(1'b1, REG_QUOTA_TWO, quota_two);
      csr_access(1'b1, REG_CAPACITY, cap);
      csr_access(1'b0, REG_QUOTA_ZERO, '0);
      csr_access(1'b0, REG_QUOTA_ONE, '0);
      csr_access(1'b0, REG_QUOTA_TWO, '0);
      csr_access(1'b0, REG_CAPACITY, '0);
   endtask

   initial begin : stimulus
      int unsigned phase;
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values of the registers.
      csr_access(1'b0, REG_QUOTA_ZERO, '0);
      csr_access(1'b0, REG_QUOTA_ONE, '0);
      csr_access(1'b0, REG_QUOTA_TWO, '0);
      csr_access(1'b0, REG_CAPACITY, '0);

      // Grants on empty queues, an ignored op code, then the clamped index.
      send_request(OP_GRANT, 2'd0, '0);
      send_request(OP_GRANT, 2'd3, '1);
      send_request(OP_UNUSED, 2'd3, '1);
      send_request(OP_ENQUEUE, 2'd0, '1);
      send_request(OP_ENQUEUE, 2'd1, '0);
      send_request(OP_ENQUEUE, 2'd2, '0);
      send_request(OP_ENQUEUE, 2'd3, '0);
      send_request(OP_ENQUEUE, 2'd0, '0);
      send_request(OP_ENQUEUE, 2'd1, '0);
      send_request(OP_GRANT, 2'd0, 18'd1);
      send_request(OP_GRANT, 2'd0, 18'd4);
      send_request(OP_ENQUEUE, 2'd3, '0);
      send_request(OP_GRANT, 2'd1, '1);
      drain_results();

      // No quota at all: only the leftover pass hands out tokens.
      load_settings('0, '0, '0, '0);
      send_request(OP_ENQUEUE, 2'd2, '0);
      send_request(OP_ENQUEUE, 2'd0, '0);
      send_request(OP_GRANT, 2'd2, 18'd1);
      send_request(OP_GRANT, 2'd0, '0);
      drain_results();

      load_settings(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'd2);
      send_request(OP_ENQUEUE, 2'd1, '0);
      send_request(OP_ENQUEUE, 2'd1, '0);
      send_request(OP_ENQUEUE, 2'd2, '0);
      send_request(OP_GRANT, 2'd0, 18'd2);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         if (phase == 2)
            load_settings($urandom, $urandom, $urandom, $urandom);
         else
            load_settings(pick_quota(), pick_quota(), pick_quota(), $urandom_range(0, 24));
         steady_flow = (phase == 1);
         repeat (ITEMS_PER_PHASE) begin
            send_random_request();
            if ($urandom_range(0, 39) == 0) drain_results();
         end
         if (phase == 3) begin
            // Keep offering while the result side is held off so the block backs up.
            steady_flow      = 1'b1;
            hold_off_request = 1'b1;
            repeat (30) send_random_request();
         end
         steady_flow = 1'b0;
      end

      // A grant that empties the queues, a back-to-back burst of enqueues into the
      // lowest priority queue, then one grant that takes everything.
      drain_results();
      load_settings(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF);
      steady_flow = 1'b1;
      send_request(OP_GRANT, 2'd0, '1);
      repeat (BURST_LENGTH)
         send_request(OP_ENQUEUE, $urandom_range(0, 1) ? 2'd2 : 2'd3, TOK_W'($urandom));
      send_request(OP_GRANT, 2'd0, '1);
      steady_flow = 1'b0;
      drain_results();

      // Shutdown is permanent, so it closes the run.
      load_settings(32'd2, 32'd1, '0, 32'd3);
      send_request(OP_ENQUEUE, 2'd0, '0);
      send_request(OP_ENQUEUE, 2'd0, '0);
      send_request(OP_ENQUEUE, 2'd1, '0);
      send_request(OP_SHUTDOWN, 2'd0, '0);
      send_request(OP_ENQUEUE, 2'd1, '0);
      send_request(OP_ENQUEUE, 2'd3, '0);
      send_request(OP_GRANT, 2'd0, '1);
      send_request(OP_SHUTDOWN, 2'd3, '1);
      send_request(OP_UNUSED, 2'd0, '0);
      send_request(OP_GRANT, 2'd2, '0);
      drain_results();

      if (tracker.failures == 0 && tracker.awaited.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule : priority_quota_batch_scheduler_test

`default_nettype wire
